@@ hw/rtl/hcm_pkg.sv @@
// Shared types, constants and codes for the homography coordinate mapper.
package hcm_pkg;

	localparam int SRC_BITS       = 12;
	localparam int COORD_BITS_DEF = 12;
	localparam int COEF_W         = 32;
	localparam int Q_W            = 32;
	localparam int BOX_MAX_W      = 31;
	localparam int CFG_IDX_W      = 3;
	localparam int W_FRAC         = 30;
	localparam int NUM_TERMS      = 6;
	localparam int DIV_STEPS      = Q_W;
	localparam int CNT_W          = $clog2(DIV_STEPS);
	localparam int LANES          = 2;

	localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sd65536;
	localparam logic signed [COEF_W-1:0] COEF_ZERO = 32'sd0;
	localparam logic signed [Q_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [Q_W-1:0] NEG_MIN = 32'sh8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_XX = 3'd0,
		REG_XY = 3'd1,
		REG_XO = 3'd2,
		REG_YX = 3'd3,
		REG_YY = 3'd4,
		REG_YO = 3'd5,
		REG_WX = 3'd6,
		REG_WY = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		TERM_XX = 3'd0,
		TERM_XY = 3'd1,
		TERM_YX = 3'd2,
		TERM_YY = 3'd3,
		TERM_WX = 3'd4,
		TERM_WY = 3'd5
	} term_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ABS,
		ST_SETUP,
		ST_DIV,
		ST_SIGN,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic [SRC_BITS-1:0] src_col;
		logic [SRC_BITS-1:0] src_row;
		logic                restart;
	} in_item_t;

	typedef struct packed {
		logic signed [Q_W-1:0] mapped_col;
		logic signed [Q_W-1:0] mapped_row;
		logic signed [Q_W-1:0] box_min_col;
		logic [BOX_MAX_W-1:0]  box_max_col;
		logic signed [Q_W-1:0] box_min_row;
		logic [BOX_MAX_W-1:0]  box_max_row;
		logic                  divide_fault;
	} out_item_t;

	typedef struct packed {
		logic  load_in;
		logic  mul_en;
		term_t mul_sel;
		logic  acc_en;
		term_t acc_sel;
		logic  abs_en;
		logic  setup_en;
		logic  div_en;
		logic  sign_en;
		logic  load_out;
	} cmd_t;

endpackage

@@ hw/rtl/hcm_ctrl.sv @@
// Sequencing state machine and output handshake for the homography coordinate mapper.
module hcm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output hcm_pkg::cmd_t cmd
);

	hcm_pkg::state_t state_q, state_d;
	logic [hcm_pkg::CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == hcm_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hcm_pkg::ST_IDLE: begin
				if (in_valid) state_d = hcm_pkg::ST_MUL;
			end
			hcm_pkg::ST_MUL: begin
				if (cnt_q == hcm_pkg::CNT_W'(hcm_pkg::NUM_TERMS)) state_d = hcm_pkg::ST_ABS;
			end
			hcm_pkg::ST_ABS:   state_d = hcm_pkg::ST_SETUP;
			hcm_pkg::ST_SETUP: state_d = hcm_pkg::ST_DIV;
			hcm_pkg::ST_DIV: begin
				if (cnt_q == hcm_pkg::CNT_W'(hcm_pkg::DIV_STEPS - 1)) state_d = hcm_pkg::ST_SIGN;
			end
			hcm_pkg::ST_SIGN:  state_d = hcm_pkg::ST_LOAD;
			hcm_pkg::ST_LOAD: begin
				if (out_free) state_d = hcm_pkg::ST_IDLE;
			end
			default: state_d = hcm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			hcm_pkg::ST_IDLE: cmd.load_in = in_valid;
			hcm_pkg::ST_MUL: begin
				cmd.mul_en  = (cnt_q < hcm_pkg::CNT_W'(hcm_pkg::NUM_TERMS));
				cmd.mul_sel = hcm_pkg::term_t'(cnt_q[2:0]);
				cmd.acc_en  = (cnt_q != '0);
				cmd.acc_sel = hcm_pkg::term_t'(cnt_q[2:0] - 3'd1);
			end
			hcm_pkg::ST_ABS:   cmd.abs_en = 1'b1;
			hcm_pkg::ST_SETUP: cmd.setup_en = 1'b1;
			hcm_pkg::ST_DIV:   cmd.div_en = 1'b1;
			hcm_pkg::ST_SIGN:  cmd.sign_en = 1'b1;
			hcm_pkg::ST_LOAD:  cmd.load_out = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hcm_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + 1'b1;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register loaded while a transaction is still pending");

	a_accept_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == hcm_pkg::ST_MUL && cnt_q == '0))
		else $error("accepted transaction did not start the multiply sequence");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hcm_pkg::ST_DIV && cnt_q == hcm_pkg::CNT_W'(hcm_pkg::DIV_STEPS - 1))
		|=> state_q == hcm_pkg::ST_SIGN)
		else $error("divide did not end after its last quotient bit");

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_in, cmd.abs_en, cmd.setup_en, cmd.div_en, cmd.sign_en,
			cmd.load_out, cmd.mul_en || cmd.acc_en}))
		else $error("more than one datapath phase commanded at once");

endmodule

@@ hw/rtl/hcm_datapath.sv @@
// Coefficient registers, multiply-accumulate, two-lane divider and bounding box.
module hcm_datapath #(
	parameter int COORD_BITS = hcm_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hcm_pkg::cmd_t                     cmd,
	input  hcm_pkg::in_item_t                 in_data,
	output hcm_pkg::out_item_t                out_data,
	input  logic                              cfg_we,
	input  logic [hcm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hcm_pkg::COEF_W-1:0]        cfg_data
);

	localparam int U = (COORD_BITS < hcm_pkg::SRC_BITS) ? COORD_BITS : hcm_pkg::SRC_BITS;
	localparam int PROD_W = hcm_pkg::COEF_W + U + 1;
	localparam int NUM_W = hcm_pkg::COEF_W + U + 2;
	localparam int Q_W = hcm_pkg::Q_W;

	logic signed [hcm_pkg::COEF_W-1:0] coef_q [8];
	logic [U-1:0] x_q, y_q;
	logic restart_q;

	logic signed [PROD_W-1:0] prod_q, prod_d;
	logic signed [hcm_pkg::COEF_W-1:0] coef_sel;
	logic [U-1:0] coord_sel;
	logic signed [U:0] coord_ext;

	logic signed [NUM_W-1:0] num_q [hcm_pkg::LANES];
	logic signed [NUM_W-1:0] w_q;

	logic [NUM_W-1:0] mag_q [hcm_pkg::LANES];
	logic [NUM_W-1:0] d_q;
	logic num_neg_q [hcm_pkg::LANES];
	logic w_neg_q, fault_q;

	logic [NUM_W-1:0] r_q [hcm_pkg::LANES];
	logic [Q_W-1:0] sh_q [hcm_pkg::LANES];
	logic [Q_W-1:0] quo_q [hcm_pkg::LANES];
	logic ovf_q [hcm_pkg::LANES];

	logic [NUM_W:0] trial [hcm_pkg::LANES];
	logic [NUM_W:0] diff [hcm_pkg::LANES];
	logic ge [hcm_pkg::LANES];

	logic signed [Q_W-1:0] res_q [hcm_pkg::LANES];
	logic signed [Q_W-1:0] res_d [hcm_pkg::LANES];

	logic signed [Q_W-1:0] min_col_q, min_row_q;
	logic [hcm_pkg::BOX_MAX_W-1:0] max_col_q, max_row_q;
	logic signed [Q_W-1:0] min_col_b, min_row_b, min_col_n, min_row_n;
	logic [hcm_pkg::BOX_MAX_W-1:0] max_col_b, max_row_b, max_col_n, max_row_n;

	hcm_pkg::out_item_t out_q;

	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[hcm_pkg::REG_XX] <= hcm_pkg::COEF_ONE;
			coef_q[hcm_pkg::REG_XY] <= hcm_pkg::COEF_ZERO;
			coef_q[hcm_pkg::REG_XO] <= hcm_pkg::COEF_ZERO;
			coef_q[hcm_pkg::REG_YX] <= hcm_pkg::COEF_ZERO;
			coef_q[hcm_pkg::REG_YY] <= hcm_pkg::COEF_ONE;
			coef_q[hcm_pkg::REG_YO] <= hcm_pkg::COEF_ZERO;
			coef_q[hcm_pkg::REG_WX] <= hcm_pkg::COEF_ZERO;
			coef_q[hcm_pkg::REG_WY] <= hcm_pkg::COEF_ZERO;
		end else if (cfg_we) begin
			coef_q[cfg_index] <= $signed(cfg_data);
		end
	end

	always_comb begin
		coef_sel  = coef_q[hcm_pkg::REG_XX];
		coord_sel = x_q;
		unique case (cmd.mul_sel)
			hcm_pkg::TERM_XX: begin coef_sel = coef_q[hcm_pkg::REG_XX]; coord_sel = x_q; end
			hcm_pkg::TERM_XY: begin coef_sel = coef_q[hcm_pkg::REG_XY]; coord_sel = y_q; end
			hcm_pkg::TERM_YX: begin coef_sel = coef_q[hcm_pkg::REG_YX]; coord_sel = x_q; end
			hcm_pkg::TERM_YY: begin coef_sel = coef_q[hcm_pkg::REG_YY]; coord_sel = y_q; end
			hcm_pkg::TERM_WX: begin coef_sel = coef_q[hcm_pkg::REG_WX]; coord_sel = x_q; end
			hcm_pkg::TERM_WY: begin coef_sel = coef_q[hcm_pkg::REG_WY]; coord_sel = y_q; end
			default: begin coef_sel = coef_q[hcm_pkg::REG_XX]; coord_sel = x_q; end
		endcase
		coord_ext = $signed({1'b0, coord_sel});
		prod_d = coef_sel * coord_ext;
	end

	always_comb begin
		for (int l = 0; l < hcm_pkg::LANES; l++) begin
			trial[l] = {r_q[l], sh_q[l][Q_W-1]};
			diff[l]  = trial[l] - {1'b0, d_q};
			ge[l]    = (trial[l] >= {1'b0, d_q});
		end
	end

	// Saturate toward the sign of the true quotient; a flagged overflow means it reached 2^32.
	always_comb begin
		for (int l = 0; l < hcm_pkg::LANES; l++) begin
			if (fault_q) begin
				res_d[l] = num_neg_q[l] ? hcm_pkg::NEG_MIN : hcm_pkg::POS_MAX;
			end else if (num_neg_q[l] ^ w_neg_q) begin
				if (ovf_q[l] || quo_q[l] > 32'h8000_0000) res_d[l] = hcm_pkg::NEG_MIN;
				else res_d[l] = -$signed(quo_q[l]);
			end else begin
				if (ovf_q[l] || quo_q[l][Q_W-1]) res_d[l] = hcm_pkg::POS_MAX;
				else res_d[l] = $signed(quo_q[l]);
			end
		end
	end

	always_comb begin
		min_col_b = restart_q ? hcm_pkg::POS_MAX : min_col_q;
		min_row_b = restart_q ? hcm_pkg::POS_MAX : min_row_q;
		max_col_b = restart_q ? '0 : max_col_q;
		max_row_b = restart_q ? '0 : max_row_q;
		min_col_n = min_col_b;
		min_row_n = min_row_b;
		max_col_n = max_col_b;
		max_row_n = max_row_b;
		if (!fault_q) begin
			if (res_q[0] < min_col_b) min_col_n = res_q[0];
			if (res_q[1] < min_row_b) min_row_n = res_q[1];
			if (res_q[0] > $signed({1'b0, max_col_b})) max_col_n = res_q[0][hcm_pkg::BOX_MAX_W-1:0];
			if (res_q[1] > $signed({1'b0, max_row_b})) max_row_n = res_q[1][hcm_pkg::BOX_MAX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_col_q <= hcm_pkg::POS_MAX;
			min_row_q <= hcm_pkg::POS_MAX;
			max_col_q <= '0;
			max_row_q <= '0;
		end else if (cmd.load_out) begin
			min_col_q <= min_col_n;
			min_row_q <= min_row_n;
			max_col_q <= max_col_n;
			max_row_q <= max_row_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_q       <= in_data.src_col[U-1:0];
			y_q       <= in_data.src_row[U-1:0];
			restart_q <= in_data.restart;
			num_q[0]  <= NUM_W'(coef_q[hcm_pkg::REG_XO]);
			num_q[1]  <= NUM_W'(coef_q[hcm_pkg::REG_YO]);
			w_q       <= NUM_W'(1) <<< hcm_pkg::W_FRAC;
		end
		if (cmd.mul_en) prod_q <= prod_d;
		if (cmd.acc_en) begin
			unique case (cmd.acc_sel)
				hcm_pkg::TERM_XX, hcm_pkg::TERM_XY: num_q[0] <= num_q[0] + NUM_W'(prod_q);
				hcm_pkg::TERM_YX, hcm_pkg::TERM_YY: num_q[1] <= num_q[1] + NUM_W'(prod_q);
				hcm_pkg::TERM_WX, hcm_pkg::TERM_WY: w_q <= w_q + NUM_W'(prod_q);
				default: w_q <= w_q;
			endcase
		end
		if (cmd.abs_en) begin
			for (int l = 0; l < hcm_pkg::LANES; l++) begin
				num_neg_q[l] <= num_q[l][NUM_W-1];
				mag_q[l] <= num_q[l][NUM_W-1] ? NUM_W'(-num_q[l]) : NUM_W'(num_q[l]);
			end
			w_neg_q <= w_q[NUM_W-1];
			d_q     <= w_q[NUM_W-1] ? NUM_W'(-w_q) : NUM_W'(w_q);
			fault_q <= (w_q == '0);
		end
		if (cmd.setup_en) begin
			for (int l = 0; l < hcm_pkg::LANES; l++) begin
				ovf_q[l] <= ({2'b00, mag_q[l]} >= {d_q, 2'b00});
				r_q[l]   <= mag_q[l] >> 2;
				sh_q[l]  <= {mag_q[l][1:0], {(Q_W-2){1'b0}}};
				quo_q[l] <= '0;
			end
		end
		if (cmd.div_en) begin
			for (int l = 0; l < hcm_pkg::LANES; l++) begin
				r_q[l]   <= ge[l] ? diff[l][NUM_W-1:0] : trial[l][NUM_W-1:0];
				quo_q[l] <= {quo_q[l][Q_W-2:0], ge[l]};
				sh_q[l]  <= sh_q[l] << 1;
			end
		end
		if (cmd.sign_en) begin
			for (int l = 0; l < hcm_pkg::LANES; l++) begin
				res_q[l] <= res_d[l];
			end
		end
		if (cmd.load_out) begin
			out_q.mapped_col   <= res_q[0];
			out_q.mapped_row   <= res_q[1];
			out_q.box_min_col  <= min_col_n;
			out_q.box_max_col  <= max_col_n;
			out_q.box_min_row  <= min_row_n;
			out_q.box_max_row  <= max_row_n;
			out_q.divide_fault <= fault_q;
		end
	end

endmodule

@@ hw/rtl/homography_coordinate_mapper.sv @@
// Top level of the homography coordinate mapper.
// Each transaction maps one pixel coordinate through the programmed 3x3 homography and returns
// the Q16.16 mapped point, the running bounding box and a fault flag for a zero divisor. The
// next transaction is accepted only after the previous one has passed through the steps in
// order: the shared multiplier forms the two numerators and the divisor, then the magnitudes
// and divider setup, then the restoring divider (one quotient bit per cycle, both coordinates
// in parallel), then sign, saturation and box update. A finished result waits in an output
// register, so a new transaction is accepted while it is pending. Coefficients must be written
// only while no transaction is in flight; the block itself does not enforce this.
module homography_coordinate_mapper #(
	parameter int COORD_BITS = hcm_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  hcm_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output hcm_pkg::out_item_t            out_data,
	input  logic                          cfg_we,
	input  logic [hcm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hcm_pkg::COEF_W-1:0]    cfg_data
);

	hcm_pkg::cmd_t cmd;

	hcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	hcm_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

@@ test/homography_coordinate_mapper_tb.sv @@
`timescale 1ns / 100ps
// Testbench that checks the homography coordinate mapper against a predictor of its mapping.
module homography_coordinate_mapper_tb;

	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 60;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	hcm_pkg::in_item_t             in_data   = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	hcm_pkg::out_item_t            out_data;
	logic                          cfg_we    = 1'b0;
	logic [hcm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [hcm_pkg::COEF_W-1:0]    cfg_data  = '0;

	int        coef [8] = '{hcm_pkg::COEF_ONE, 0, 0, 0, hcm_pkg::COEF_ONE, 0, 0, 0};
	longint    least_col = longint'(hcm_pkg::POS_MAX);
	longint    most_col = 0;
	longint    least_row = longint'(hcm_pkg::POS_MAX);
	longint    most_row = 0;
	hcm_pkg::out_item_t expected_maps [$];
	hcm_pkg::out_item_t want;
	int        mismatch_count = 0;
	int        idle_cycles = 0;
	bit        steady = 1'b0;

	homography_coordinate_mapper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void clear_box();
		least_col = longint'(hcm_pkg::POS_MAX);
		most_col  = 0;
		least_row = longint'(hcm_pkg::POS_MAX);
		most_row  = 0;
	endfunction

	// The quotient is (num << 30) / den on magnitudes, truncated, then signed and saturated.
	function automatic logic signed [hcm_pkg::Q_W-1:0] divide_q(longint num, longint den);
		logic [127:0] mag_n;
		logic [127:0] mag_d;
		logic [127:0] quo;
		bit           neg;
		neg   = (num < 0) != (den < 0);
		mag_n = (num < 0) ? 128'(-num) : 128'(num);
		mag_d = (den < 0) ? 128'(-den) : 128'(den);
		quo   = (mag_n << hcm_pkg::W_FRAC) / mag_d;
		if (neg)
			return (quo > 128'h8000_0000) ? hcm_pkg::NEG_MIN : hcm_pkg::Q_W'(-quo);
		return (quo > 128'h7FFF_FFFF) ? hcm_pkg::POS_MAX : hcm_pkg::Q_W'(quo);
	endfunction

	function automatic hcm_pkg::out_item_t map_pixel(hcm_pkg::in_item_t px);
		longint    x;
		longint    y;
		longint    num_col;
		longint    num_row;
		longint    den;
		longint    col_q;
		longint    row_q;
		hcm_pkg::out_item_t res;
		x = longint'(px.src_col);
		y = longint'(px.src_row);
		if (px.restart)
			clear_box();
		num_col = longint'(coef[hcm_pkg::REG_XX]) * x + longint'(coef[hcm_pkg::REG_XY]) * y
			+ longint'(coef[hcm_pkg::REG_XO]);
		num_row = longint'(coef[hcm_pkg::REG_YX]) * x + longint'(coef[hcm_pkg::REG_YY]) * y
			+ longint'(coef[hcm_pkg::REG_YO]);
		den = longint'(coef[hcm_pkg::REG_WX]) * x + longint'(coef[hcm_pkg::REG_WY]) * y
			+ (longint'(1) << hcm_pkg::W_FRAC);
		res.divide_fault = (den == 0);
		if (den == 0) begin
			col_q = longint'((num_col >= 0) ? hcm_pkg::POS_MAX : hcm_pkg::NEG_MIN);
			row_q = longint'((num_row >= 0) ? hcm_pkg::POS_MAX : hcm_pkg::NEG_MIN);
		end else begin
			col_q = longint'(divide_q(num_col, den));
			row_q = longint'(divide_q(num_row, den));
			if (col_q > most_col) most_col = col_q;
			if (col_q < least_col) least_col = col_q;
			if (row_q > most_row) most_row = row_q;
			if (row_q < least_row) least_row = row_q;
		end
		res.mapped_col  = col_q[31:0];
		res.mapped_row  = row_q[31:0];
		res.box_min_col = least_col[31:0];
		res.box_max_col = most_col[30:0];
		res.box_min_row = least_row[31:0];
		res.box_max_row = most_row[30:0];
		return res;
	endfunction

	function automatic int pick_gap();
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(3, 1);
		if (roll < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic int spread(int mag);
		return int'($urandom_range(2 * mag)) - mag;
	endfunction

	function automatic int pick_extreme();
		unique case ($urandom_range(5))
			0: return hcm_pkg::POS_MAX;
			1: return hcm_pkg::NEG_MIN;
			2: return 0;
			3: return hcm_pkg::COEF_ONE;
			4: return -hcm_pkg::COEF_ONE;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [hcm_pkg::SRC_BITS-1:0] pick_coord();
		int roll;
		roll = $urandom_range(9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return hcm_pkg::SRC_BITS'($urandom_range(2 ** hcm_pkg::SRC_BITS - 1));
	endfunction

	task automatic compare_field(input string field, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s expected %h, got %h", $time, field, exp_v, got_v);
			mismatch_count++;
		end
	endtask

	task automatic load_matrix(input int mat [8]);
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= hcm_pkg::CFG_IDX_W'(i);
			cfg_data  <= mat[i];
			coef[i] = mat[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic send_pixel(input logic [hcm_pkg::SRC_BITS-1:0] col,
			input logic [hcm_pkg::SRC_BITS-1:0] row, input bit restart);
		int                gap;
		hcm_pkg::in_item_t px;
		px.src_col = col;
		px.src_row = row;
		px.restart = restart;
		in_data  <= px;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_maps = {expected_maps, map_pixel(px)};
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		if (in_valid)
			in_valid <= 1'b0;
		while (expected_maps.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_reset_identity();
		send_pixel(0, 0, 1'b1);
		send_pixel(4095, 4095, 1'b0);
		send_pixel(4095, 0, 1'b0);
		send_pixel(0, 4095, 1'b0);
		send_pixel(1, 2, 1'b0);
		drain_results();
	endtask

	task automatic test_saturation();
		int mat [8];
		mat[hcm_pkg::REG_XX] = hcm_pkg::POS_MAX;
		mat[hcm_pkg::REG_XY] = hcm_pkg::POS_MAX;
		mat[hcm_pkg::REG_XO] = hcm_pkg::POS_MAX;
		mat[hcm_pkg::REG_YX] = hcm_pkg::POS_MAX;
		mat[hcm_pkg::REG_YY] = hcm_pkg::POS_MAX;
		mat[hcm_pkg::REG_YO] = hcm_pkg::POS_MAX;
		mat[hcm_pkg::REG_WX] = 0;
		mat[hcm_pkg::REG_WY] = 0;
		load_matrix(mat);
		send_pixel(4095, 4095, 1'b1);
		send_pixel(0, 0, 1'b0);
		send_pixel(1, 0, 1'b0);
		drain_results();
		mat[hcm_pkg::REG_XX] = hcm_pkg::NEG_MIN;
		mat[hcm_pkg::REG_XY] = hcm_pkg::NEG_MIN;
		mat[hcm_pkg::REG_XO] = hcm_pkg::NEG_MIN;
		mat[hcm_pkg::REG_YX] = hcm_pkg::NEG_MIN;
		mat[hcm_pkg::REG_YY] = hcm_pkg::NEG_MIN;
		mat[hcm_pkg::REG_YO] = hcm_pkg::NEG_MIN;
		mat[hcm_pkg::REG_WX] = hcm_pkg::POS_MAX;
		mat[hcm_pkg::REG_WY] = hcm_pkg::NEG_MIN;
		load_matrix(mat);
		send_pixel(0, 0, 1'b1);
		send_pixel(4095, 0, 1'b0);
		send_pixel(0, 4095, 1'b0);
		send_pixel(4095, 4095, 1'b0);
		send_pixel(2048, 2047, 1'b0);
		drain_results();
	endtask

	task automatic test_zero_divisor();
		int mat [8];
		mat[hcm_pkg::REG_XX] = hcm_pkg::COEF_ONE;
		mat[hcm_pkg::REG_XY] = 0;
		mat[hcm_pkg::REG_XO] = -hcm_pkg::COEF_ONE;
		mat[hcm_pkg::REG_YX] = -3 * hcm_pkg::COEF_ONE;
		mat[hcm_pkg::REG_YY] = hcm_pkg::COEF_ONE;
		mat[hcm_pkg::REG_YO] = 0;
		mat[hcm_pkg::REG_WX] = -(1 << hcm_pkg::W_FRAC);
		mat[hcm_pkg::REG_WY] = -(1 << (hcm_pkg::W_FRAC - 1));
		load_matrix(mat);
		send_pixel(0, 0, 1'b1);
		send_pixel(1, 0, 1'b0);
		send_pixel(0, 2, 1'b0);
		send_pixel(1, 0, 1'b1);
		send_pixel(2, 0, 1'b0);
		send_pixel(3, 1, 1'b0);
		send_pixel(4095, 4095, 1'b0);
		drain_results();
	endtask

	// Kinds: 0 mild perspective, 1 affine, 2 perspective tuned to hit a zero divisor,
	// 3 coefficients drawn from the extremes and the full range.
	task automatic random_phase(input int kind, input int count);
		int                           mat [8];
		int                           shift;
		bit                           on_row;
		logic [hcm_pkg::SRC_BITS-1:0] col;
		logic [hcm_pkg::SRC_BITS-1:0] row;
		shift  = $urandom_range(hcm_pkg::SRC_BITS - 1);
		on_row = 1'($urandom_range(1));
		if (kind == 3) begin
			for (int i = 0; i < 8; i++)
				mat[i] = pick_extreme();
		end else begin
			mat[hcm_pkg::REG_XX] = hcm_pkg::COEF_ONE + spread(32768);
			mat[hcm_pkg::REG_XY] = spread(16384);
			mat[hcm_pkg::REG_XO] = spread(1 << 26);
			mat[hcm_pkg::REG_YX] = spread(16384);
			mat[hcm_pkg::REG_YY] = hcm_pkg::COEF_ONE + spread(32768);
			mat[hcm_pkg::REG_YO] = spread(1 << 26);
			mat[hcm_pkg::REG_WX] = spread(1 << 18);
			mat[hcm_pkg::REG_WY] = spread(1 << 18);
		end
		if (kind == 1) begin
			mat[hcm_pkg::REG_XX] = spread(1 << 19);
			mat[hcm_pkg::REG_YY] = spread(1 << 19);
			mat[hcm_pkg::REG_WX] = 0;
			mat[hcm_pkg::REG_WY] = 0;
		end
		if (kind == 2) begin
			mat[hcm_pkg::REG_WX] = on_row ? 0 : -(1 << (hcm_pkg::W_FRAC - shift));
			mat[hcm_pkg::REG_WY] = on_row ? -(1 << (hcm_pkg::W_FRAC - shift)) : 0;
		end
		load_matrix(mat);
		for (int k = 0; k < count; k++) begin
			col = pick_coord();
			row = pick_coord();
			if (kind == 2 && $urandom_range(99) < 35) begin
				if (on_row)
					row = hcm_pkg::SRC_BITS'(1 << shift);
				else
					col = hcm_pkg::SRC_BITS'(1 << shift);
			end
			send_pixel(col, row, k == 0 || $urandom_range(9) == 0);
		end
		drain_results();
	endtask

	task automatic test_random_matrices();
		for (int p = 0; p < 8; p++) begin
			steady = (p == 5);
			random_phase(p % 4, 50);
		end
		steady = 1'b0;
	endtask

	initial begin
		int hold;
		wait (arst_n);
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(16, 1)) @(posedge clk);
			hold = pick_gap();
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_maps.size() == 0) begin
				$display("%0t: result with no expectation waiting: %p", $time, out_data);
				mismatch_count++;
			end else begin
				want = expected_maps.pop_front();
				compare_field("mapped_col", want.mapped_col, out_data.mapped_col);
				compare_field("mapped_row", want.mapped_row, out_data.mapped_row);
				compare_field("box_min_col", want.box_min_col, out_data.box_min_col);
				compare_field("box_max_col", 32'(want.box_max_col),
					32'(out_data.box_max_col));
				compare_field("box_min_row", want.box_min_row, out_data.box_min_row);
				compare_field("box_max_row", 32'(want.box_max_row),
					32'(out_data.box_max_row));
				compare_field("divide_fault", 32'(want.divide_fault),
					32'(out_data.divide_fault));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_identity();
		test_saturation();
		test_zero_divisor();
		test_random_matrices();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
